// ===== rtl/skdt_pkg.sv =====
// ----------------------------------------------------------------------------
// skdt_pkg - shared types and constants of the sigmoid (tanh) kernel
// Field widths, register indexes, datapath operations and the exp factor table.
// ----------------------------------------------------------------------------
package skdt_pkg;

	// field widths
	localparam int ElemW     = 16;
	localparam int ResultW   = 16;
	localparam int CfgW      = 32;
	localparam int CfgIndexW = 1;
	localparam int AccW      = 48;
	localparam int ProdW     = 32;

	// stream word widths
	localparam int InDataW  = 2 * ElemW;
	localparam int OutDataW = ResultW;

	// configuration register indexes
	localparam logic [CfgIndexW-1:0] REG_GAIN   = 1'd0;
	localparam logic [CfgIndexW-1:0] REG_OFFSET = 1'd1;

	// register reset values
	localparam logic [CfgW-1:0] GAIN_RESET   = 32'd65536;
	localparam logic [CfgW-1:0] OFFSET_RESET = 32'd0;

	// iteration counts of the tanh engine
	localparam int StepW     = 5;
	localparam int ExpSteps  = 21;
	localparam int DivSteps  = 16;
	localparam logic [StepW-1:0] EXP_LAST = StepW'(ExpSteps - 1);
	localparam logic [StepW-1:0] DIV_LAST = StepW'(DivSteps - 1);

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_ABS      = 4'd1,
		OP_MUL_LO   = 4'd2,
		OP_MUL_HI   = 4'd3,
		OP_SCALE    = 4'd4,
		OP_OFFS     = 4'd5,
		OP_CLAMP    = 4'd6,
		OP_EXP_MUL  = 4'd7,
		OP_EXP_UPD  = 4'd8,
		OP_DIV_INIT = 4'd9,
		OP_DIV_STEP = 4'd10,
		OP_LOAD     = 4'd11
	} op_t;

	// command from controller to datapath
	typedef struct packed {
		logic             take;
		op_t              op;
		logic [StepW-1:0] step;
	} cmd_t;

	// exp(-2^(k-16)) in Q.24
	function automatic logic [23:0] exp_factor(input logic [StepW-1:0] k);
		logic [23:0] f;
		case (k)
			5'd0:    f = 24'd16776960;
			5'd1:    f = 24'd16776704;
			5'd2:    f = 24'd16776192;
			5'd3:    f = 24'd16775168;
			5'd4:    f = 24'd16773120;
			5'd5:    f = 24'd16769026;
			5'd6:    f = 24'd16760840;
			5'd7:    f = 24'd16744480;
			5'd8:    f = 24'd16711808;
			5'd9:    f = 24'd16646655;
			5'd10:   f = 24'd16517109;
			5'd11:   f = 24'd16261035;
			5'd12:   f = 24'd15760736;
			5'd13:   f = 24'd14805841;
			5'd14:   f = 24'd13066109;
			5'd15:   f = 24'd10175896;
			5'd16:   f = 24'd6171993;
			5'd17:   f = 24'd2270549;
			5'd18:   f = 24'd307285;
			5'd19:   f = 24'd5628;
			5'd20:   f = 24'd2;
			default: f = 24'd0;
		endcase
		return f;
	endfunction

endpackage

// ===== rtl/skdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// skdt_ctrl - sequencer of the sigmoid (tanh) kernel
// Accepts element pairs, then steps the datapath through scaling, exp and divide.
// ----------------------------------------------------------------------------
module skdt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output skdt_pkg::cmd_t cmd
);
	import skdt_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE     = 13'b0000000000001,
		S_DRAIN    = 13'b0000000000010,
		S_ABS      = 13'b0000000000100,
		S_MUL_LO   = 13'b0000000001000,
		S_MUL_HI   = 13'b0000000010000,
		S_SCALE    = 13'b0000000100000,
		S_OFFS     = 13'b0000001000000,
		S_CLAMP    = 13'b0000010000000,
		S_EXP_MUL  = 13'b0000100000000,
		S_EXP_UPD  = 13'b0001000000000,
		S_DIV_INIT = 13'b0010000000000,
		S_DIV      = 13'b0100000000000,
		S_OUT      = 13'b1000000000000
	} state_t;

	state_t           state_q, state_d;
	logic [StepW-1:0] step_q, step_d;
	logic             out_valid_q;
	logic             take;
	logic             load;

	// request handshake
	assign s_tready = (state_q == S_IDLE);
	assign take     = s_tvalid & s_tready;
	assign load     = (state_q == S_OUT) & (~out_valid_q | m_tready);
	assign m_tvalid = out_valid_q;

	// next state and step counter
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			S_IDLE:     if (take && s_tlast) state_d = S_DRAIN;
			S_DRAIN:    state_d = S_ABS;
			S_ABS:      state_d = S_MUL_LO;
			S_MUL_LO:   state_d = S_MUL_HI;
			S_MUL_HI:   state_d = S_SCALE;
			S_SCALE:    state_d = S_OFFS;
			S_OFFS:     state_d = S_CLAMP;
			S_CLAMP: begin
				state_d = S_EXP_MUL;
				step_d  = '0;
			end
			S_EXP_MUL:  state_d = S_EXP_UPD;
			S_EXP_UPD: begin
				if (step_q == EXP_LAST) begin
					state_d = S_DIV_INIT;
					step_d  = '0;
				end else begin
					state_d = S_EXP_MUL;
					step_d  = step_q + 1'b1;
				end
			end
			S_DIV_INIT: state_d = S_DIV;
			S_DIV: begin
				if (step_q == DIV_LAST) begin
					state_d = S_OUT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_OUT:      if (load) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd.take = take;
		cmd.step = step_q;
		case (state_q)
			S_ABS:      cmd.op = OP_ABS;
			S_MUL_LO:   cmd.op = OP_MUL_LO;
			S_MUL_HI:   cmd.op = OP_MUL_HI;
			S_SCALE:    cmd.op = OP_SCALE;
			S_OFFS:     cmd.op = OP_OFFS;
			S_CLAMP:    cmd.op = OP_CLAMP;
			S_EXP_MUL:  cmd.op = OP_EXP_MUL;
			S_EXP_UPD:  cmd.op = OP_EXP_UPD;
			S_DIV_INIT: cmd.op = OP_DIV_INIT;
			S_DIV:      cmd.op = OP_DIV_STEP;
			S_OUT:      cmd.op = load ? OP_LOAD : OP_NONE;
			default:    cmd.op = OP_NONE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/skdt_dp.sv =====
// ----------------------------------------------------------------------------
// skdt_dp - datapath of the sigmoid (tanh) kernel
// Multiply-accumulate, gain scaling on a shared multiplier, exp product, divider.
// ----------------------------------------------------------------------------
module skdt_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  skdt_pkg::cmd_t                  cmd,
	input  logic [skdt_pkg::ElemW-1:0]      elem_a,
	input  logic [skdt_pkg::ElemW-1:0]      elem_b,
	input  logic                            last,
	input  logic                            cfg_wen,
	input  logic [skdt_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [skdt_pkg::CfgW-1:0]       cfg_wdata,
	output logic [skdt_pkg::ResultW-1:0]    kernel_value
);
	import skdt_pkg::*;

	// configuration
	logic signed [CfgW-1:0] gain_q, offset_q;

	// multiply-accumulate pipeline
	logic signed [ProdW-1:0] prod_mul;
	logic signed [ProdW-1:0] prod_s1;
	logic                    vld_s1, last_s1;
	logic signed [AccW:0]    acc_sum;
	logic signed [AccW-1:0]  acc_sat;
	logic signed [AccW-1:0]  acc_q, dot_q;

	// scaling
	logic [AccW-1:0]  am_q;
	logic [CfgW-1:0]  gm_q;
	logic             neg_q;
	logic [31:0]      mul_a, mul_b;
	logic [63:0]      mul_p;
	logic [63:0]      prod_q, plo_q;
	logic [55:0]      mag_full;
	logic [40:0]      mag_q;
	logic signed [42:0] smag, arg_q;
	logic signed [20:0] x_clamp;
	logic [19:0]      absx;

	// tanh engine
	logic             xneg_q;
	logic [20:0]      y_q;
	logic [24:0]      e_q;
	logic [48:0]      e_rnd;
	logic [25:0]      den_init;
	logic [39:0]      dvd_init;
	logic [25:0]      den_q, rem_q;
	logic [15:0]      quo_q;
	logic [26:0]      trial;
	logic             trial_ge;
	logic [15:0]      q_sat;
	logic [ResultW-1:0] out_q;

	// element product
	assign prod_mul = $signed(elem_a) * $signed(elem_b);

	// saturating accumulate
	assign acc_sum = {acc_q[AccW-1], acc_q} + (AccW+1)'(prod_s1);
	always_comb begin
		if (acc_sum[AccW] != acc_sum[AccW-1]) begin
			acc_sat = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[AccW-1:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			OP_MUL_LO: begin
				mul_a = am_q[31:0];
				mul_b = gm_q;
			end
			OP_MUL_HI: begin
				mul_a = {16'd0, am_q[AccW-1:32]};
				mul_b = gm_q;
			end
			OP_EXP_MUL: begin
				mul_a = {7'd0, e_q};
				mul_b = {8'd0, exp_factor(cmd.step)};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// rounded Q.16 magnitude of gain times dot
	assign mag_full = {prod_q[47:0], 8'd0} + 56'(plo_q[63:24]) + 56'(plo_q[23]);

	// signed magnitude
	assign smag = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});

	// clamp to plus or minus eight
	always_comb begin
		if (arg_q > 43'sd524288) begin
			x_clamp = 21'sd524288;
		end else if (arg_q < -43'sd524288) begin
			x_clamp = -21'sd524288;
		end else begin
			x_clamp = arg_q[20:0];
		end
	end
	assign absx = x_clamp[20] ? 20'(-x_clamp) : x_clamp[19:0];

	// exp step rounding
	assign e_rnd = prod_q[48:0] + 49'(24'h800000);

	// divider set-up: (num + den/2) / den
	assign den_init = 26'(25'h1000000) + 26'(e_q);
	assign dvd_init = {(25'h1000000 - e_q), 15'd0} + 40'(den_init[25:1]);

	// restoring divide step
	assign trial    = {rem_q, quo_q[15]};
	assign trial_ge = (trial >= {1'b0, den_q});

	// output saturation
	assign q_sat = (quo_q > 16'd32767) ? 16'd32767 : quo_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= OFFSET_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_GAIN:   gain_q   <= cfg_wdata;
				REG_OFFSET: offset_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// accumulator control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= cmd.take;
			if (vld_s1) begin
				acc_q <= last_s1 ? '0 : acc_sat;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prod_s1 <= prod_mul;
			last_s1 <= last;
		end
		if (vld_s1 && last_s1) begin
			dot_q <= acc_sat;
		end
		case (cmd.op)
			OP_ABS: begin
				am_q  <= dot_q[AccW-1] ? AccW'(-dot_q) : dot_q;
				gm_q  <= gain_q[CfgW-1] ? CfgW'(-gain_q) : gain_q;
				neg_q <= dot_q[AccW-1] ^ gain_q[CfgW-1];
			end
			OP_MUL_LO: prod_q <= mul_p;
			OP_MUL_HI: begin
				plo_q  <= prod_q;
				prod_q <= mul_p;
			end
			OP_SCALE: mag_q <= (mag_full > 56'h100_0000_0000) ? 41'h100_0000_0000
			                                                   : mag_full[40:0];
			OP_OFFS: arg_q <= smag + 43'(offset_q);
			OP_CLAMP: begin
				xneg_q <= arg_q[42];
				y_q    <= {absx, 1'b0};
				e_q    <= 25'h1000000;
			end
			OP_EXP_MUL: prod_q <= mul_p;
			OP_EXP_UPD: if (y_q[cmd.step]) e_q <= e_rnd[48:24];
			OP_DIV_INIT: begin
				den_q <= den_init;
				rem_q <= 26'(dvd_init[39:16]);
				quo_q <= dvd_init[15:0];
			end
			OP_DIV_STEP: begin
				rem_q <= trial_ge ? 26'(trial - {1'b0, den_q}) : trial[25:0];
				quo_q <= {quo_q[14:0], trial_ge};
			end
			OP_LOAD: out_q <= xneg_q ? 16'(-q_sat) : q_sat;
			default: ;
		endcase
	end

	assign kernel_value = out_q;

endmodule

// ===== rtl/sigmoid_kernel_dot_tanh.sv =====
// ----------------------------------------------------------------------------
// sigmoid_kernel_dot_tanh - tanh kernel on a streamed dot product
// Accumulates products of element pairs, then gives tanh(gain * dot + offset).
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata: elem_a, elem_b; s_tlast: last
//  m_*       out        m_tvalid/m_tready  m_tdata: kernel_value (Q1.15)
//  cfg_*     in         cfg_wen            cfg_index 0 gain, 1 offset; cfg_wdata
//
//  a pair that is not last is taken while idle; pairs stream back to back
//  after the last pair no pair is taken during scaling, a 21-step exp product on the
//  shared 32x32 multiplier (a multiply and an update state a step) and a 16-step restoring divide
//  a finished result waits in the output register; new pairs are taken meanwhile
//  reset clears the accumulator and loads gain 1.0 and offset 0
// ----------------------------------------------------------------------------
module sigmoid_kernel_dot_tanh (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [skdt_pkg::InDataW-1:0]      s_tdata,   // elem_a [15:0], elem_b [31:16]
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [skdt_pkg::OutDataW-1:0]     m_tdata,   // kernel_value [15:0]
	input  logic                              cfg_wen,
	input  logic [skdt_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [skdt_pkg::CfgW-1:0]         cfg_wdata
);
	import skdt_pkg::*;

	cmd_t cmd;

	// sequencer
	skdt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// arithmetic
	skdt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.elem_a       (s_tdata[ElemW-1:0]),
		.elem_b       (s_tdata[2*ElemW-1:ElemW]),
		.last         (s_tlast),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.kernel_value (m_tdata)
	);

endmodule

// ===== bench/sigmoid_kernel_dot_tanh_tb.sv =====
// ----------------------------------------------------------------------------
// sigmoid_kernel_dot_tanh_tb - self-checking bench for the tanh kernel
// Streams element pairs with random gaps and output back-pressure, predicts
// every kernel value with a fixed-point model of its own and compares each
// result as it leaves the block.
// ----------------------------------------------------------------------------
module sigmoid_kernel_dot_tanh_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import skdt_pkg::*;

	typedef struct packed {
		logic [ElemW-1:0] elem_a;
		logic [ElemW-1:0] elem_b;
		logic             last;
		logic             no_gap;
	} pair_t;

	localparam longint          AccMax      = 64'sh7FFF_FFFF_FFFF;
	localparam longint          AccMin      = -AccMax - 1;
	localparam longint          ArgLimit    = 8 * 65536;
	localparam longint unsigned MagCap      = 64'd1 << 40;
	localparam longint unsigned OneQ24      = 64'd1 << 24;
	localparam int              DrainCycles = 100;
	localparam int              HoldCycles  = 600;

	// exp(-2^(k-16)) in Q.24
	logic [23:0] exp_tab [21] = '{
		24'd16776960, 24'd16776704, 24'd16776192, 24'd16775168, 24'd16773120,
		24'd16769026, 24'd16760840, 24'd16744480, 24'd16711808, 24'd16646655,
		24'd16517109, 24'd16261035, 24'd15760736, 24'd14805841, 24'd13066109,
		24'd10175896, 24'd6171993,  24'd2270549,  24'd307285,   24'd5628,
		24'd2
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [InDataW-1:0]   s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OutDataW-1:0]  m_tdata;
	logic                 cfg_wen   = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = REG_GAIN;
	logic [CfgW-1:0]      cfg_wdata = '0;

	// pending pairs and kernel values still to come out
	pair_t              pair_q [$];
	logic [ResultW-1:0] kv_q [$];

	// shadow of the block's registers and accumulator
	int     gain_reg   = GAIN_RESET;
	int     offset_reg = OFFSET_RESET;
	longint dot_sum    = 0;

	// sender and receiver state
	pair_t cur_pair;
	logic  pair_busy    = 1'b0;
	logic  pair_done    = 1'b0;
	int    gap_left     = 0;
	logic  src_gaps     = 1'b1;
	logic  result_done  = 1'b0;
	logic  stall_armed  = 1'b0;
	int    stall_left   = 0;
	logic  rcv_stalls   = 1'b1;
	logic  hold_arm     = 1'b0;
	logic  hold_used    = 1'b0;
	int    hold_left    = 0;
	int    mismatch_cnt = 0;
	int    random_items = 0;

	sigmoid_kernel_dot_tanh u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // elem_a [15:0], elem_b [31:16]
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // kernel_value [15:0]
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always #5 clk = ~clk;

	// tanh of a clamped Q.16 argument, as Q1.15
	function automatic logic [ResultW-1:0] tanh_q15(input longint x);
		logic            neg;
		longint unsigned y;
		longint unsigned e;
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		neg = x < 0;
		y = (neg ? -x : x) * 2;
		e = OneQ24;
		for (int k = 0; k < 21; k++) begin
			if (y[k]) begin
				e = (e * exp_tab[k] + (OneQ24 >> 1)) >> 24;
			end
		end
		num = (OneQ24 - e) << 15;
		den = OneQ24 + e;
		q = (num + den / 2) / den;
		if (q > 32767) begin
			q = 32767;
		end
		return neg ? ResultW'(-longint'(q)) : ResultW'(q);
	endfunction

	// tanh(gain * dot + offset) for a finished Q.24 dot product
	function automatic logic [ResultW-1:0] kernel_value(input longint sum, input longint g,
			input longint offs);
		logic            neg;
		longint unsigned am;
		longint unsigned gm;
		longint unsigned mag;
		logic [95:0]     prod;
		longint          arg;
		neg = (sum < 0) != (g < 0);
		am = sum < 0 ? -sum : sum;
		gm = g < 0 ? -g : g;
		// exact product, rounded half away from zero down to Q.16
		prod = 96'(am) * 96'(gm) + (96'd1 << 23);
		mag = 64'(prod >> 24);
		if (mag > MagCap) begin
			mag = MagCap;
		end
		arg = neg ? -longint'(mag) : longint'(mag);
		arg = arg + offs;
		if (arg > ArgLimit) begin
			arg = ArgLimit;
		end
		if (arg < -ArgLimit) begin
			arg = -ArgLimit;
		end
		return tanh_q15(arg);
	endfunction

	function automatic int rand_elem(input int mode);
		int v;
		case (mode)
			0: v = int'($urandom_range(0, 65535)) - 32768;
			1: v = int'($urandom_range(0, 8192)) - 4096;
			2: v = int'($urandom_range(0, 512)) - 256;
			default: begin
				case ($urandom_range(0, 4))
					0:       v = -32768;
					1:       v = 32767;
					2:       v = 0;
					3:       v = -1;
					default: v = 1;
				endcase
			end
		endcase
		return v;
	endfunction

	function automatic logic [CfgW-1:0] rand_gain();
		logic [CfgW-1:0] v;
		case ($urandom_range(0, 3))
			0:       v = $urandom;
			1:       v = $urandom_range(0, 1 << 18) - (1 << 17);
			2:       v = $urandom_range(0, 2048) - 1024;
			default: v = 65536 + $urandom_range(0, 8192) - 4096;
		endcase
		return v;
	endfunction

	function automatic logic [CfgW-1:0] rand_offset();
		logic [CfgW-1:0] v;
		case ($urandom_range(0, 3))
			0:       v = $urandom;
			1:       v = $urandom_range(0, 1 << 20) - (1 << 19);
			2:       v = $urandom_range(0, 1 << 16) - (1 << 15);
			default: v = '0;
		endcase
		return v;
	endfunction

	task automatic add_pair(input int a, input int b, input logic last, input logic no_gap = 1'b0);
		pair_t p;
		p.elem_a = ElemW'(a);
		p.elem_b = ElemW'(b);
		p.last   = last;
		p.no_gap = no_gap;
		pair_q.push_back(p);
	endtask

	task automatic add_vector(input int len, input int mode);
		for (int i = 0; i < len; i++) begin
			add_pair(rand_elem(mode), rand_elem(mode), i == len - 1);
		end
	endtask

	// random vectors, mostly short, now and then a long one
	task automatic add_random(input int n);
		int made;
		int len;
		int pick;
		int mode;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = $urandom_range(1, 4);
			end else if (pick < 90) begin
				len = $urandom_range(5, 16);
			end else if (pick < 98) begin
				len = $urandom_range(17, 64);
			end else begin
				len = $urandom_range(100, 400);
			end
			// last vector of the batch is cut to fit
			if (len > n - made) begin
				len = n - made;
			end
			pick = $urandom_range(0, 9);
			mode = pick < 2 ? 0 : pick < 6 ? 1 : pick < 9 ? 2 : 3;
			add_vector(len, mode);
			made += len;
		end
		random_items += made;
	endtask

	// wait until every request is taken and every result is out, then let the block settle
	task automatic drain();
		while (pair_q.size() != 0 || pair_busy || kv_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_GAIN) begin
			gain_reg = val;
		end else begin
			offset_reg = val;
		end
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic set_config(input logic [CfgW-1:0] g, input logic [CfgW-1:0] offs);
		write_reg(REG_GAIN, g);
		write_reg(REG_OFFSET, offs);
	endtask

	// request accepted: fold the pair into the dot product, predict on the last one
	always @(posedge clk) begin : take_pair
		longint nsum;
		if (arst_n && s_tvalid && s_tready) begin
			nsum = dot_sum + longint'($signed(s_tdata[ElemW-1:0]))
				* longint'($signed(s_tdata[2*ElemW-1:ElemW]));
			if (nsum > AccMax) begin
				nsum = AccMax;
			end
			if (nsum < AccMin) begin
				nsum = AccMin;
			end
			if (s_tlast) begin
				kv_q.push_back(kernel_value(nsum, gain_reg, offset_reg));
				dot_sum = 0;
			end else begin
				dot_sum = nsum;
			end
			pair_done = 1'b1;
		end
	end

	// sender: next request after a random gap
	always @(negedge clk) begin : drive_pairs
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (pair_done) begin
				pair_done = 1'b0;
				pair_busy = 1'b0;
			end
			if (!pair_busy && pair_q.size() != 0) begin
				cur_pair  = pair_q.pop_front();
				pair_busy = 1'b1;
				gap_left  = (cur_pair.no_gap || !src_gaps) ? 0 : $urandom_range(0, 10);
			end
			if (pair_busy && gap_left == 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {cur_pair.elem_b, cur_pair.elem_a};
				s_tlast  <= cur_pair.last;
			end else begin
				s_tvalid <= 1'b0;
				if (pair_busy) begin
					gap_left = gap_left - 1;
				end
			end
		end
	end

	// compare each kernel value with the oldest prediction
	always @(posedge clk) begin : check_results
		logic [ResultW-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (kv_q.size() == 0) begin
				$display("%0t ns: kernel_value mismatch, expected none, actual %0d",
					$time, $signed(m_tdata));
				mismatch_cnt++;
			end else begin
				want = kv_q.pop_front();
				if (m_tdata !== want) begin
					$display("%0t ns: kernel_value mismatch, expected %0d, actual %0d",
						$time, $signed(want), $signed(m_tdata));
					mismatch_cnt++;
				end
			end
			result_done = 1'b1;
		end
	end

	// long receiver hold-off, started once by the sequence
	always @(posedge clk) begin
		if (hold_arm && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HoldCycles;
		end else if (hold_left != 0) begin
			hold_left = hold_left - 1;
		end
	end

	// receiver: random stall once a result shows up
	always @(negedge clk) begin : drive_ready
		if (result_done) begin
			result_done = 1'b0;
			stall_armed = 1'b0;
		end
		if (m_tvalid && !stall_armed) begin
			stall_armed = 1'b1;
			stall_left  = rcv_stalls ? $urandom_range(0, 10) : 0;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0 || hold_left != 0) begin
			m_tready <= 1'b0;
			if (stall_left != 0) begin
				stall_left = stall_left - 1;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	// test sequence
	initial begin : run
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset values: field extremes, sign cases, clamping of the argument
		add_pair(-32768, -32768, 1'b1);
		add_pair(32767, -32768, 1'b1);
		add_pair(0, 0, 1'b1);
		add_pair(1, 1, 1'b1);
		add_pair(-1, 1, 1'b1);
		add_pair(4096, 1024, 1'b1);
		add_pair(-4096, 2048, 1'b1);
		add_pair(32767, 32767, 1'b1);
		add_pair(-32768, 32767, 1'b1);
		// vector that cancels to zero
		add_pair(8192, 4096, 1'b0);
		add_pair(-8192, 4096, 1'b0);
		add_pair(0, -32768, 1'b1);
		// mixed signs over several pairs
		add_pair(1000, -3000, 1'b0);
		add_pair(-7000, -500, 1'b0);
		add_pair(123, 456, 1'b0);
		add_pair(-32768, 1, 1'b1);
		drain();

		// largest gain: scaled term hits its magnitude cap
		set_config(32'h7FFF_FFFF, 32'h0000_0000);
		for (int i = 0; i < 16; i++) begin
			add_pair(-32768, -32768, i == 15);
		end
		add_pair(1, 1, 1'b1);
		add_pair(0, 5, 1'b1);
		add_random(100);
		drain();

		// most negative gain, largest offset
		set_config(32'h8000_0000, 32'h7FFF_FFFF);
		add_pair(-32768, -32768, 1'b1);
		add_pair(0, 0, 1'b1);
		add_random(100);
		drain();

		// zero gain, most negative offset
		set_config(32'h0000_0000, 32'h8000_0000);
		add_pair(32767, 32767, 1'b1);
		add_random(20);
		drain();

		// back-pressure: receiver holds off while requests keep coming
		set_config(32'h0001_0000, 32'h0000_0000);
		src_gaps = 1'b0;
		rcv_stalls = 1'b0;
		hold_arm = 1'b1;
		for (int i = 0; i < 40; i++) begin
			add_vector($urandom_range(1, 3), 1);
		end
		drain();

		// random phases with random settings and idling patterns
		for (int ph = 0; ph < 8; ph++) begin
			set_config(rand_gain(), rand_offset());
			src_gaps = ph[0];
			rcv_stalls = ph[1] | ph[2];
			add_random(140);
			drain();
		end

		if (mismatch_cnt == 0 && kv_q.size() == 0) begin
			$display("sigmoid_kernel_dot_tanh regression: pass");
		end else begin
			$display("sigmoid_kernel_dot_tanh regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("sigmoid_kernel_dot_tanh regression: fail");
		$finish;
	end

endmodule
